// ----- rtl/rldd_pkg.sv -----
package rldd_pkg;

    // Field widths fixed by the stream format.
    localparam int BUF_W    = 64;
    localparam int CNT_W    = 7;
    localparam int STRIDE_W = 17;

    // Request operations.
    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_PUSH    = 2'd1;
    localparam logic [1:0] OP_PULL    = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // Decoder phases.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_RUN    = 2'd1;
    localparam logic [1:0] PH_DELTA  = 2'd2;
    localparam logic [1:0] PH_END    = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_STRIDE = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // One result, as it travels from the decoder to the output buffer.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       need_word;
        logic       stream_end;
        logic [2:0] skip_out;
        logic [1:0] status;
    } result_t;

endpackage

// ----- rtl/rldd_line_store.sv -----
module rldd_line_store #(
    parameter int DEPTH = 65536
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [7:0]                               wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [7:0]                               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;
    logic [7:0] fwd_data_reg;
    logic       fwd_reg;

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg        <= mem[raddr];
        fwd_data_reg <= wdata;
    end

    // A read of the entry written at the same edge returns the new byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = fwd_reg ? fwd_data_reg : q_reg;

endmodule

// ----- rtl/rldd_decode.sv -----
module rldd_decode #(
    parameter int MAX_STRIDE = 65536
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               take,
    input  logic [1:0]                                         op,
    input  logic [31:0]                                        stream_word,
    input  logic [7:0]                                         back_data,
    output logic                                               mem_we,
    output logic [$clog2(MAX_STRIDE > 1 ? MAX_STRIDE : 2)-1:0] mem_waddr,
    output logic [7:0]                                         mem_wdata,
    output logic [$clog2(MAX_STRIDE > 1 ? MAX_STRIDE : 2)-1:0] mem_raddr,
    output rldd_pkg::result_t                                  res
);

    localparam int AW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
    localparam int SW = rldd_pkg::STRIDE_W;
    localparam logic [SW:0] MAX_EXT = MAX_STRIDE[SW:0];
    localparam logic [AW:0] WRAP    = MAX_STRIDE[AW:0];

    logic [rldd_pkg::BUF_W-1:0] buf_reg, buf_next;
    logic [rldd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                 phase_reg, phase_next;
    logic [6:0]                 run_left_reg, run_left_next;
    logic [3:0]                 dw_reg, dw_next;
    logic [SW-1:0]              stride_reg, stride_next;
    logic [2:0]                 skip_reg, skip_next;
    logic [7:0]                 last_reg, last_next;
    logic [SW-1:0]              done_reg, done_next;
    logic [7:0]                 older_reg, older_next;
    logic [AW-1:0]              wr_ptr_reg, wr_ptr_next;

    logic [6:0]                 shamt;
    logic [rldd_pkg::BUF_W-1:0] window;
    logic [5:0]                 off;
    logic [6:0]                 avail;
    logic [6:0]                 run_f;
    logic [2:0]                 code_f;
    logic [7:0]                 top8;
    logic [7:0]                 dval;
    logic [8:0]                 half9;
    logic [7:0]                 act;
    logic [7:0]                 back;
    logic                       too_big;
    logic                       need;
    logic                       valid;
    logic [1:0]                 st;
    logic [AW:0]                wp_inc;
    logic [SW:0]                wp_ext;
    logic [SW:0]                ra_ext;

    // Request decode: restart, push a word, or pull as far as one byte.
    always_comb
    begin
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        phase_next    = phase_reg;
        run_left_next = run_left_reg;
        dw_next       = dw_reg;
        stride_next   = stride_reg;
        skip_next     = skip_reg;
        last_next     = last_reg;
        done_next     = done_reg;
        older_next    = older_reg;
        wr_ptr_next   = wr_ptr_reg;
        need          = 1'b0;
        valid         = 1'b0;
        st            = rldd_pkg::ST_OK;
        off           = 6'd0;
        avail         = 7'd0;
        run_f         = 7'd0;
        code_f        = 3'd0;
        top8          = 8'd0;
        dval          = 8'd0;
        half9         = 9'd0;
        act           = 8'd0;
        back          = older_reg;
        too_big       = 1'b0;
        wp_inc        = '0;
        mem_we        = 1'b0;
        mem_wdata     = 8'd0;

        // Buffered bits aligned so that the next stream bit sits at the top.
        shamt  = 7'd64 - cnt_reg;
        window = buf_reg << shamt;

        if (take)
        begin
            unique case (op)
                rldd_pkg::OP_RESTART:
                begin
                    buf_next      = '0;
                    cnt_next      = '0;
                    phase_next    = rldd_pkg::PH_HEADER;
                    run_left_next = 7'd0;
                    dw_next       = 4'd0;
                    stride_next   = {{(SW-1){1'b0}}, 1'b1};
                    skip_next     = 3'd1;
                    last_next     = 8'd0;
                    done_next     = '0;
                    older_next    = 8'd0;
                    wr_ptr_next   = '0;
                end
                rldd_pkg::OP_PUSH:
                begin
                    if (cnt_reg > 7'd32)
                    begin
                        st = rldd_pkg::ST_FULL;
                    end
                    else
                    begin
                        buf_next = {buf_reg[31:0], stream_word};
                        cnt_next = cnt_reg + 7'd32;
                    end
                end
                rldd_pkg::OP_PULL:
                begin
                    // Stream header.
                    if (phase_reg == rldd_pkg::PH_HEADER)
                    begin
                        if (cnt_reg >= 7'd18)
                        begin
                            skip_next   = {1'b0, window[63:62]} + 3'd1;
                            stride_next = {1'b0, window[61:46]} + 17'd1;
                            phase_next  = rldd_pkg::PH_RUN;
                            off         = 6'd18;
                        end
                        else
                        begin
                            need = 1'b1;
                        end
                    end

                    // Run header; a zero count needs only its own bits.
                    if (!need && phase_next == rldd_pkg::PH_RUN)
                    begin
                        avail = cnt_reg - {1'b0, off};
                        if (off == 6'd0)
                        begin
                            run_f  = window[63:57];
                            code_f = window[56:54];
                        end
                        else
                        begin
                            run_f  = window[45:39];
                            code_f = window[38:36];
                        end
                        if (avail >= 7'd7 && run_f == 7'd0)
                        begin
                            phase_next = rldd_pkg::PH_END;
                            off        = off + 6'd7;
                        end
                        else if (avail >= 7'd10)
                        begin
                            run_left_next = run_f;
                            dw_next       = (code_f == 3'd0) ? 4'd0 : {1'b0, code_f} + 4'd1;
                            phase_next    = rldd_pkg::PH_DELTA;
                            off           = off + 6'd10;
                        end
                        else
                        begin
                            need = 1'b1;
                        end
                    end

                    too_big = {1'b0, stride_next} > MAX_EXT;
                    if (phase_next != rldd_pkg::PH_HEADER && too_big)
                    begin
                        st = rldd_pkg::ST_STRIDE;
                    end

                    // One delta gives one byte.
                    if (!need && phase_next == rldd_pkg::PH_DELTA)
                    begin
                        avail = cnt_reg - {1'b0, off};
                        if (avail >= {3'b000, dw_next})
                        begin
                            case (off)
                                6'd0:    top8 = window[63:56];
                                6'd10:   top8 = window[53:46];
                                default: top8 = window[35:28];
                            endcase
                            dval  = top8 >> (4'd8 - dw_next);
                            half9 = (9'd1 << dw_next) >> 1;
                            act   = last_reg + dval - half9[7:0];

                            // Line term from the store, and the store update.
                            if (!too_big)
                            begin
                                if (done_reg >= stride_next)
                                begin
                                    back = back_data;
                                    if (done_reg > stride_next)
                                    begin
                                        act = act + back - older_reg;
                                    end
                                end
                                mem_we      = 1'b1;
                                mem_wdata   = act;
                                wp_inc      = {1'b0, wr_ptr_reg} + {{AW{1'b0}}, 1'b1};
                                wr_ptr_next = (wp_inc == WRAP) ? '0 : wp_inc[AW-1:0];
                                older_next  = back;
                            end

                            last_next = act;
                            if (done_reg <= stride_next)
                            begin
                                done_next = done_reg + 17'd1;
                            end
                            run_left_next = run_left_next - 7'd1;
                            if (run_left_next == 7'd0)
                            begin
                                phase_next = rldd_pkg::PH_RUN;
                            end
                            valid = 1'b1;
                            off   = off + {2'b00, dw_next};
                        end
                        else
                        begin
                            need = 1'b1;
                        end
                    end

                    cnt_next = cnt_reg - {1'b0, off};
                end
                default:
                begin
                end
            endcase
        end
    end

    // Prefetch the store entry one stride behind the next write position.
    always_comb
    begin
        wp_ext                = '0;
        wp_ext[AW-1:0]        = wr_ptr_next;
        if (wp_ext >= {1'b0, stride_next})
        begin
            ra_ext = wp_ext - {1'b0, stride_next};
        end
        else
        begin
            ra_ext = wp_ext + MAX_EXT - {1'b0, stride_next};
        end
    end

    assign mem_raddr = ra_ext[AW-1:0];
    assign mem_waddr = wr_ptr_reg;

    // Result of this request.
    assign res.byte_out   = valid ? act : 8'd0;
    assign res.byte_valid = valid;
    assign res.need_word  = need;
    assign res.stream_end = (phase_next == rldd_pkg::PH_END);
    assign res.skip_out   = skip_next;
    assign res.status     = st;

    // Decode state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg      <= '0;
            cnt_reg      <= '0;
            phase_reg    <= rldd_pkg::PH_HEADER;
            run_left_reg <= 7'd0;
            dw_reg       <= 4'd0;
            stride_reg   <= {{(SW-1){1'b0}}, 1'b1};
            skip_reg     <= 3'd1;
            last_reg     <= 8'd0;
            done_reg     <= '0;
            older_reg    <= 8'd0;
            wr_ptr_reg   <= '0;
        end
        else
        begin
            buf_reg      <= buf_next;
            cnt_reg      <= cnt_next;
            phase_reg    <= phase_next;
            run_left_reg <= run_left_next;
            dw_reg       <= dw_next;
            stride_reg   <= stride_next;
            skip_reg     <= skip_next;
            last_reg     <= last_next;
            done_reg     <= done_next;
            older_reg    <= older_next;
            wr_ptr_reg   <= wr_ptr_next;
        end
    end

endmodule

// ----- rtl/rldd_out_buf.sv -----
module rldd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rldd_pkg::result_t din,
    output logic              out_valid,
    input  logic              out_stall,
    output rldd_pkg::result_t dout
);

    rldd_pkg::result_t main_reg, main_next;
    rldd_pkg::result_t skid_reg, skid_next;
    logic              main_v_reg, main_v_next;
    logic              skid_v_reg, skid_v_next;
    logic              take;

    assign in_stall  = skid_v_reg;
    assign take      = in_valid && !skid_v_reg;
    assign out_valid = main_v_reg;
    assign dout      = main_reg;

    // Output register with a skid entry behind it.
    always_comb
    begin
        main_next   = main_reg;
        main_v_next = main_v_reg;
        skid_next   = skid_reg;
        skid_v_next = skid_v_reg;
        if (!main_v_reg || !out_stall)
        begin
            if (skid_v_reg)
            begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                main_next   = din;
                main_v_next = take;
            end
        end
        else if (take)
        begin
            skid_next   = din;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- rtl/run_length_delta_byte_decoder.sv -----
// Run-length delta byte decoder. Every request (restart, push a 32-bit stream word,
// or pull one byte) gives one result, so a new request can enter on every clock while
// in_stall is low; the result is registered in the output stage once the request
// is accepted. The rate is set by the line store, a single memory of MAX_STRIDE bytes
// with one write and one registered read per cycle: the entry one stride back is read
// in the cycle before a pull needs it, with forwarding when it is the entry just
// written. The output stage holds two results, so one more request is taken after
// the output stalls. The line store needs no clearing after reset.
module run_length_delta_byte_decoder #(
    parameter int MAX_STRIDE = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] stream_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_out,
    output logic        byte_valid,
    output logic        need_word,
    output logic        stream_end,
    output logic [2:0]  skip_out,
    output logic [1:0]  status
);

    localparam int AW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;

    logic              in_fire;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [7:0]        mem_rdata;
    rldd_pkg::result_t dec_res;
    rldd_pkg::result_t out_res;

    assign in_fire = in_valid && !in_stall;

    // Stream parser and byte reconstruction.
    rldd_decode #(
        .MAX_STRIDE (MAX_STRIDE)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (in_fire),
        .op          (op),
        .stream_word (stream_word),
        .back_data   (mem_rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .res         (dec_res)
    );

    // Previous line of decoded bytes.
    rldd_line_store #(
        .DEPTH (MAX_STRIDE)
    ) u_line_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result register and skid entry.
    rldd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .din       (dec_res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dout      (out_res)
    );

    assign byte_out   = out_res.byte_out;
    assign byte_valid = out_res.byte_valid;
    assign need_word  = out_res.need_word;
    assign stream_end = out_res.stream_end;
    assign skip_out   = out_res.skip_out;
    assign status     = out_res.status;

endmodule

// ----- rtl/rldd_checker.sv -----
module rldd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  byte_out,
    input logic        byte_valid,
    input logic        need_word,
    input logic        stream_end,
    input logic [2:0]  skip_out,
    input logic [1:0]  status
);

    // A stalled request stays on offer.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("request dropped while stalled");

    // A stalled result stays on offer; its byte, byte_valid, need_word and status do not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_out) && $stable(byte_valid)
            && $stable(need_word) && $stable(status))
        else $error("stalled result changed");

    // A decoded byte never comes with a request for a word, a full status or the end of the stream.
    a_byte_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !need_word && !stream_end
            && status != rldd_pkg::ST_FULL)
        else $error("decoded byte with conflicting flags");

    // Without a decoded byte the byte field is zero.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> byte_out == 8'd0)
        else $error("byte field set without a decoded byte");

    // The interleave skip stays in its range.
    a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> skip_out >= 3'd1 && skip_out <= 3'd4)
        else $error("interleave skip out of range");

endmodule

bind run_length_delta_byte_decoder rldd_checker u_rldd_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int LINE_STORE_DEPTH = 65536;
    // Cycles with no request and no result accepted before the run is abandoned.
    localparam int QUIET_LIMIT      = 4000;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  op          = rldd_pkg::OP_RESTART;
    logic [31:0] stream_word = 32'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic        need_word;
    logic        stream_end;
    logic [2:0]  skip_out;
    logic [1:0]  status;

    run_length_delta_byte_decoder #(
        .MAX_STRIDE(LINE_STORE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .stream_word(stream_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .byte_out(byte_out),
        .byte_valid(byte_valid),
        .need_word(need_word),
        .stream_end(stream_end),
        .skip_out(skip_out),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Decoder state as the predictor sees it.
    logic [63:0] dec_buf;
    logic [6:0]  dec_cnt;
    logic [1:0]  dec_phase;
    logic [6:0]  dec_run_left;
    logic [3:0]  dec_width;
    logic [16:0] dec_stride;
    logic [2:0]  dec_skip;
    logic [7:0]  dec_last;
    logic [16:0] dec_done;
    logic [7:0]  dec_older;
    logic [15:0] dec_wr;
    logic [7:0]  line_mem [0:LINE_STORE_DEPTH-1];

    rldd_pkg::result_t expected_results [$];
    logic [31:0]       stream_words [$];
    bit                stream_bits [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int mismatches     = 0;
    int items_sent     = 0;
    int streams_played = 0;
    int bytes_decoded  = 0;
    int starved_pulls  = 0;
    int dropped_pushes = 0;

    function automatic logic [63:0] ones_below(int n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [31:0] peek_bits(int n);
        return 32'((dec_buf >> (dec_cnt - n)) & ones_below(n));
    endfunction

    function automatic logic [31:0] take_bits(int n);
        logic [31:0] v;
        if (n == 0)
            return 32'd0;
        v = peek_bits(n);
        dec_cnt = dec_cnt - 7'(n);
        dec_buf &= ones_below(dec_cnt);
        return v;
    endfunction

    // Clears the decode state; the line store keeps its contents.
    function automatic void restart_decoder();
        dec_buf      = '0;
        dec_cnt      = '0;
        dec_phase    = rldd_pkg::PH_HEADER;
        dec_run_left = '0;
        dec_width    = '0;
        dec_stride   = 17'd1;
        dec_skip     = 3'd1;
        dec_last     = '0;
        dec_done     = '0;
        dec_older    = '0;
        dec_wr       = '0;
    endfunction

    // One delta applied to the previous byte, plus the line term once a full
    // stride plus one has been decoded.
    function automatic logic [7:0] decode_next();
        logic [7:0] d;
        logic [7:0] half;
        logic [7:0] act;
        logic [7:0] back;
        d    = 8'(take_bits(dec_width));
        half = (dec_width == 0) ? 8'd0 : 8'(1 << (dec_width - 1));
        act  = dec_last + d - half;
        back = dec_older;
        if (!(dec_stride > LINE_STORE_DEPTH))
        begin
            if (dec_done >= dec_stride)
            begin
                back = line_mem[16'(dec_wr - dec_stride[15:0])];
                if (dec_done > dec_stride)
                    act = act + back - dec_older;
            end
            line_mem[dec_wr] = act;
            dec_wr    = dec_wr + 16'd1;
            dec_older = back;
        end
        dec_last = act;
        if (dec_done <= dec_stride)
            dec_done = dec_done + 17'd1;
        dec_run_left = dec_run_left - 7'd1;
        if (dec_run_left == 0)
            dec_phase = rldd_pkg::PH_RUN;
        return act;
    endfunction

    // Expected result of one accepted request; advances the predicted state.
    function automatic rldd_pkg::result_t predict_result(logic [1:0] req_op,
                                                         logic [31:0] req_word);
        rldd_pkg::result_t r;
        logic              need;
        logic [1:0]        st;
        logic [2:0]        code;
        r    = '0;
        need = 1'b0;
        st   = rldd_pkg::ST_OK;
        case (req_op)
            rldd_pkg::OP_RESTART:
                restart_decoder();
            rldd_pkg::OP_PUSH:
                if (dec_cnt > 32)
                begin
                    st = rldd_pkg::ST_FULL;
                    dropped_pushes++;
                end
                else
                begin
                    dec_buf = {dec_buf[31:0], req_word};
                    dec_cnt = dec_cnt + 7'd32;
                end
            rldd_pkg::OP_PULL:
            begin
                if (dec_phase == rldd_pkg::PH_HEADER)
                begin
                    if (dec_cnt >= 18)
                    begin
                        dec_skip   = 3'(take_bits(2) + 1);
                        dec_stride = 17'(take_bits(16)) + 17'd1;
                        dec_phase  = rldd_pkg::PH_RUN;
                    end
                    else
                        need = 1'b1;
                end
                if (!need && dec_phase == rldd_pkg::PH_RUN)
                begin
                    // A zero count ends the stream and needs only its own bits.
                    if (dec_cnt >= 7 && peek_bits(7) == 0)
                    begin
                        void'(take_bits(7));
                        dec_phase = rldd_pkg::PH_END;
                    end
                    else if (dec_cnt >= 10)
                    begin
                        dec_run_left = 7'(take_bits(7));
                        code         = 3'(take_bits(3));
                        dec_width    = (code == 0) ? 4'd0 : {1'b0, code} + 4'd1;
                        dec_phase    = rldd_pkg::PH_DELTA;
                    end
                    else
                        need = 1'b1;
                end
                // The 16-bit stride field cannot exceed the store, but keep the rule.
                if (dec_phase != rldd_pkg::PH_HEADER && dec_stride > LINE_STORE_DEPTH)
                    st = rldd_pkg::ST_STRIDE;
                if (!need && dec_phase == rldd_pkg::PH_DELTA)
                begin
                    if (dec_cnt >= dec_width)
                    begin
                        r.byte_out   = decode_next();
                        r.byte_valid = 1'b1;
                        bytes_decoded++;
                    end
                    else
                        need = 1'b1;
                end
                if (need)
                    starved_pulls++;
            end
            default:
                ;
        endcase
        r.need_word  = need;
        r.stream_end = (dec_phase == rldd_pkg::PH_END);
        r.skip_out   = dec_skip;
        r.status     = st;
        return r;
    endfunction

    // Offers one request, with random idle cycles ahead of it, and records its
    // expected result once it is accepted.
    task automatic send_request(input logic [1:0] req_op, input logic [31:0] req_word);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        op          <= req_op;
        stream_word <= req_word;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_result(req_op, req_word));
        items_sent++;
    endtask

    // Holds the sender off until every outstanding result has been checked.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        rldd_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected result, byte_out", 32'(byte_out), 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (byte_out !== want.byte_out)
            report_mismatch("byte_out", 32'(byte_out), 32'(want.byte_out));
        if (byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 32'(byte_valid), 32'(want.byte_valid));
        if (need_word !== want.need_word)
            report_mismatch("need_word", 32'(need_word), 32'(want.need_word));
        if (stream_end !== want.stream_end)
            report_mismatch("stream_end", 32'(stream_end), 32'(want.stream_end));
        if (skip_out !== want.skip_out)
            report_mismatch("skip_out", 32'(skip_out), 32'(want.skip_out));
        if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
    endtask

    // Receiver: checks each accepted result, stalls at random and tracks quiet cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    task automatic append_field(input logic [31:0] value, input int nbits);
        for (int i = nbits - 1; i >= 0; i--)
            stream_bits.push_back(value[i]);
    endtask

    // Builds a well-formed stream in stream_words. A code_sel of 8 picks a
    // random width code for each run.
    task automatic build_stream(input logic [1:0] skip_f, input logic [15:0] stride_f,
                                input int runs, input int min_cnt, input int max_cnt,
                                input int code_sel);
        int          count;
        int          code;
        int          width;
        logic [31:0] w;
        stream_bits.delete();
        stream_words.delete();
        append_field(32'(skip_f), 2);
        append_field(32'(stride_f), 16);
        for (int r = 0; r < runs; r++)
        begin
            count = $urandom_range(min_cnt, max_cnt);
            code  = (code_sel == 8) ? $urandom_range(7) : code_sel;
            width = (code == 0) ? 0 : code + 1;
            append_field(count, 7);
            append_field(code, 3);
            for (int k = 0; k < count; k++)
                if (width > 0)
                    append_field($urandom_range((1 << width) - 1), width);
        end
        append_field(0, 7);
        while (stream_bits.size() % 32 != 0)
            stream_bits.push_back(1'($urandom_range(1)));
        for (int i = 0; i < stream_bits.size(); i += 32)
        begin
            w = '0;
            for (int j = 0; j < 32; j++)
                w = {w[30:0], stream_bits[i + j]};
            stream_words.push_back(w);
        end
    endtask

    // Restarts and feeds stream_words, pulling as it goes. A cut_after above
    // zero abandons the stream after that many requests.
    task automatic play_stream(input int cut_after);
        int next_word;
        int sent_here;
        int tail;
        next_word = 0;
        sent_here = 0;
        tail      = $urandom_range(3);
        send_request(rldd_pkg::OP_RESTART, $urandom);
        streams_played++;
        forever
        begin
            if (cut_after > 0 && sent_here >= cut_after)
                break;
            if (dec_phase == rldd_pkg::PH_END)
            begin
                if (tail == 0)
                    break;
                tail--;
                case ($urandom_range(2))
                    0: send_request(rldd_pkg::OP_PULL, $urandom);
                    1: send_request(rldd_pkg::OP_PUSH, $urandom);
                    default: send_request(rldd_pkg::OP_UNUSED, $urandom);
                endcase
            end
            else if (next_word < stream_words.size() && dec_cnt <= 32 && $urandom_range(1))
            begin
                send_request(rldd_pkg::OP_PUSH, stream_words[next_word]);
                next_word++;
            end
            else if (next_word < stream_words.size() && dec_cnt > 32
                     && $urandom_range(9) == 0)
                // Buffer full: this push is dropped, so the word is offered again later.
                send_request(rldd_pkg::OP_PUSH, stream_words[next_word]);
            else
                send_request(rldd_pkg::OP_PULL, $urandom);
            sent_here++;
        end
    endtask

    task automatic test_empty_pull_and_unused_op();
        send_request(rldd_pkg::OP_PULL, 32'hFFFF_FFFF);
        send_request(rldd_pkg::OP_UNUSED, 32'hFFFF_FFFF);
    endtask

    // All-ones words: largest skip and stride, count 127 and 8-bit deltas,
    // a pull that starves mid-run and a push into a full buffer.
    task automatic test_all_ones_words();
        send_request(rldd_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_request(rldd_pkg::OP_PULL, 32'd0);
        send_request(rldd_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_request(rldd_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_request(rldd_pkg::OP_PULL, 32'd0);
        send_request(rldd_pkg::OP_PULL, 32'd0);
        send_request(rldd_pkg::OP_RESTART, 32'hFFFF_FFFF);
    endtask

    // An all-zero word ends the stream at once; pulls and pushes after the end.
    task automatic test_zero_stream();
        send_request(rldd_pkg::OP_PUSH, 32'd0);
        send_request(rldd_pkg::OP_PULL, 32'd0);
        send_request(rldd_pkg::OP_PULL, 32'd0);
        send_request(rldd_pkg::OP_PUSH, $urandom);
    endtask

    // Zero-width deltas on a short line, so the line term alone moves the bytes.
    task automatic test_zero_width_run();
        build_stream(2'd2, 16'd1, 1, 5, 5, 0);
        play_stream(0);
    endtask

    task automatic test_random_streams(input int n_items);
        int          target;
        int          kind;
        logic [15:0] stride_f;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            case ($urandom_range(9))
                0: stride_f = 16'hFFFF;
                1: stride_f = 16'($urandom);
                default: stride_f = 16'($urandom_range(5));
            endcase
            kind = $urandom_range(19);
            if (kind < 2)
            begin
                // Noise: random words read as a stream, abandoned part way.
                stream_words.delete();
                repeat ($urandom_range(1, 5))
                    stream_words.push_back($urandom);
                play_stream($urandom_range(1, 30));
            end
            else
            begin
                build_stream(2'($urandom), stride_f, $urandom_range(1, 4), 1,
                             ($urandom_range(19) == 0) ? 127 : 12, 8);
                play_stream((kind < 5) ? $urandom_range(1, 20) : 0);
            end
            if ($urandom_range(9) == 0)
                wait_all_results();
        end
    endtask

    initial
    begin
        restart_decoder();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pull_and_unused_op();
        test_all_ones_words();
        test_zero_stream();
        test_zero_width_run();
        wait_all_results();

        send_idle_pct  = 16;
        recv_stall_pct = 69;
        test_random_streams(270);
        wait_all_results();

        send_idle_pct  = 69;
        recv_stall_pct = 16;
        test_random_streams(270);
        wait_all_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_streams(270);
        wait_all_results();
        repeat (8) @(posedge clk);

        $display("covered %0d requests over %0d streams, %0d bytes decoded",
                 items_sent, streams_played, bytes_decoded);
        $display("%0d pulls starved of bits, %0d pushes refused by a full buffer",
                 starved_pulls, dropped_pushes);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
